@@ src/mwo_pkg.sv @@
// Package for the multi-waveform oscillator: waveform codes, register indexes,
// sine polynomial constants and the sine table function. No dependencies.
package mwo_pkg;

  localparam int NUM_OSC_DEF     = 4;
  localparam int HARMONICS_DEF   = 16;
  localparam int SINE_DEPTH_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // WF_MUTE: undefined code, also used for an index with no oscillator
  typedef enum logic [2:0] {
    WF_SINE = 3'd0, WF_SQUARE = 3'd1, WF_TRI = 3'd2,
    WF_FSAW = 3'd3, WF_SAW = 3'd4, WF_NOISE = 3'd5, WF_MUTE = 3'd7
  } wave_t;

  localparam logic [2:0] REG_WAVE  = 3'd0;
  localparam logic [2:0] REG_OCT   = 3'd1;
  localparam logic [2:0] REG_DEPTH = 3'd2;
  localparam logic [2:0] REG_RATE  = 3'd3;
  localparam logic [2:0] REG_MINF  = 3'd4;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [63:0] K_C1 = 64'd1686629713;
  localparam logic [63:0] K_C3 = 64'd693598668;
  localparam logic [63:0] K_C5 = 64'd85569305;
  localparam logic [63:0] K_C7 = 64'd5026995;
  localparam logic [63:0] K_C9 = 64'd172272;
  localparam logic [63:0] K_TWO_OVER_PI = 64'd683565276;

  // Sine table entry for table index idx out of 2^lg entries; folded to
  // constants per entry at elaboration when used on a small table.
  function automatic logic signed [16:0] sine_entry(input logic [11:0] idx, input int lg);
    logic [31:0] a;
    logic [63:0] u, u2, t, s, v;
    a = 32'({idx, 20'd0} << (12 - lg));
    u = {34'd0, a[29:0]};
    if (a[30]) u = 64'h4000_0000 - u;
    u2 = (u * u) >> 30;
    t = K_C9;
    t = K_C7 - ((u2 * t) >> 30);
    t = K_C5 - ((u2 * t) >> 30);
    t = K_C3 - ((u2 * t) >> 30);
    t = K_C1 - ((u2 * t) >> 30);
    s = (u * t) >> 30;
    v = (s + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return a[31] ? -$signed({1'b0, v[15:0]}) : $signed({1'b0, v[15:0]});
  endfunction

endpackage

@@ src/multi_waveform_oscillator_lfo_unit.sv @@
// Top level of the multi-waveform oscillator with sine LFO.
// Depends on mwo_pkg (codes, constants, sine table function).
//
// Usage: one input beat {osc_index, sample_time, frequency} yields one
// output beat holding a signed Q1.15 sample. Items are processed one at a
// time by a sequencer around a serial multiplier that takes 4 multiplier
// bits per cycle (48-bit accumulator). The sine comes from a quarter-wave
// constant table read on the phase register. Saw, noise and undefined codes
// skip the LFO products, and an index at or above NUM_OSC goes straight to
// the last state. For the Fourier saw each harmonic takes a table read plus
// a restoring divide by n.
// in_tready is high whenever the sequencer is idle, so the next item starts
// while the last sample waits in the output register. If out_tready holds
// off, a finished sample waits in the last state until the register drains.
// Reset (rst_n low, synchronous) loads the register defaults and the noise
// LFSR seed and empties the output register. Config writes take effect at once;
// the user must make them only while no item is in flight; the block does not check.
module multi_waveform_oscillator_lfo_unit #(
  parameter int NUM_OSC          = mwo_pkg::NUM_OSC_DEF,
  parameter int HARMONICS        = mwo_pkg::HARMONICS_DEF,
  parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = mwo_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [23:0] frequency, [55:24] sample_time, [57:56] osc_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int LG = $clog2(SINE_TABLE_DEPTH);
  localparam int HW = $clog2(HARMONICS + 1);
  localparam int QW = LG - 2;
  localparam int QD = SINE_TABLE_DEPTH / 4;

  // sequencer states
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001, S_MUL = 11'b00000000010, S_BASE = 11'b00000000100,
    S_LPH  = 11'b00000001000, S_D   = 11'b00000010000, S_LSIN = 11'b00000100000,
    S_OFF  = 11'b00001000000, S_PH  = 11'b00010000000, S_FIN  = 11'b00100000000,
    S_HSIN = 11'b01000000000, S_DIV = 11'b10000000000
  } state_t;

  state_t      st_r, ret_r;
  logic [11:0] wave_r;
  logic [15:0] oct_r, rate_r, lfsr_r;
  logic [23:0] depth_r, minf_r, freq_r;
  logic [31:0] time_r, base_r, mplier_r, hph_r;
  logic [47:0] mcand_r, acc_r;
  logic [2:0]  mcnt_r;
  logic [2:0]  wf_r;
  logic [3:0]  octv_r;
  logic [31:0] dval_r;
  logic signed [16:0] sin_r;
  logic [HW-1:0] n_r;
  logic [5:0]  dcnt_r;
  logic [23:0] dq_r, drem_r;
  logic signed [47:0] fsum_r;
  logic        neg_r;
  logic        ovalid_r;
  logic [15:0] odata_r;

  logic signed [16:0] qtab [QD];
  logic [LG-1:0] tidx;
  logic [QW-1:0] tfold;
  logic [14:0]   tmag;
  logic signed [16:0] tab;
  logic [47:0] mstep;
  logic [24:0] dtrial;
  logic [31:0] tri_m;
  logic signed [16:0] tri_v;
  logic [31:0] mag32;
  logic [61:0] fprod;
  logic [23:0] p24;
  logic signed [16:0] fs_v;
  logic [15:0] smp;
  logic [15:0] lfsr_nx;
  logic        fin_go;

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign fin_go     = (st_r == S_FIN) && (!ovalid_r || out_tready);

  // quarter-wave constant table, first quadrant magnitudes
  for (genvar k = 0; k < QD; k++) begin : g_qtab
    assign qtab[k] = mwo_pkg::sine_entry(12'(k), LG);
  end

  // table sine of the phase register: fold odd quadrants, negate the upper half of the phase range
  assign tidx  = hph_r[31 -: LG];
  assign tfold = tidx[LG-2] ? (QW'(0) - tidx[QW-1:0]) : tidx[QW-1:0];
  assign tmag  = (tidx[LG-2] && (tidx[QW-1:0] == '0)) ? 15'd32767 : qtab[tfold][14:0];
  assign tab   = tidx[LG-1] ? -$signed({2'b0, tmag}) : $signed({2'b0, tmag});

  // one multiplier digit per cycle
  assign mstep  = acc_r + (mcand_r * 48'(mplier_r[3:0]));
  assign dtrial = {drem_r, dq_r[23]} - 25'(n_r);

  assign tri_m = hph_r[30] ? (32'h4000_0000 - {2'd0, hph_r[29:0]}) : {2'd0, hph_r[29:0]};
  assign tri_v = (tri_m[31:15] > 17'd32767) ? 17'sd32767 : $signed({1'b0, tri_m[30:15]});

  // harmonic sum magnitude stays below 2^26, so a 32 x 30 constant product
  assign mag32 = fsum_r < 0 ? 32'(-fsum_r) : 32'(fsum_r);
  assign fprod = 62'(mag32) * 62'(mwo_pkg::K_TWO_OVER_PI);
  assign p24   = fprod[61:38];
  always_comb begin
    if (fsum_r < 0) fs_v = (p24 > 24'd32768) ? -17'sd32768 : -$signed({1'b0, p24[15:0]});
    else fs_v = (p24 > 24'd32767) ? 17'sd32767 : $signed({1'b0, p24[15:0]});
  end

  assign lfsr_nx = lfsr_r[0] ? ((lfsr_r >> 1) ^ mwo_pkg::LFSR_TAPS) : (lfsr_r >> 1);

  always_comb begin
    smp = 16'(~((17'd1 << ((SAMPLE_BITS < 16) ? (16 - SAMPLE_BITS) : 0)) - 17'd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ret_r <= S_IDLE; ovalid_r <= 1'b0;
      wave_r <= '0; oct_r <= 16'd4369; depth_r <= '0; rate_r <= '0; minf_r <= '0;
      lfsr_r <= mwo_pkg::LFSR_SEED;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mwo_pkg::REG_WAVE:  wave_r  <= cfg_data[11:0];
          mwo_pkg::REG_OCT:   oct_r   <= cfg_data[15:0];
          mwo_pkg::REG_DEPTH: depth_r <= cfg_data;
          mwo_pkg::REG_RATE:  rate_r  <= cfg_data[15:0];
          mwo_pkg::REG_MINF:  minf_r  <= cfg_data;
          default: ;
        endcase
      end
      if (ovalid_r && out_tready && !fin_go) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            freq_r <= in_tdata[23:0]; time_r <= in_tdata[55:24];
            octv_r <= 4'(oct_r >> (4 * in_tdata[57:56]));
            if (32'(in_tdata[57:56]) >= NUM_OSC) begin
              // no such oscillator: silent sample, LFSR left alone
              wf_r <= mwo_pkg::WF_MUTE; st_r <= S_FIN;
            end else begin
              wf_r <= 3'(wave_r >> (3 * in_tdata[57:56]));
              mcand_r <= 48'(in_tdata[23:0]); mplier_r <= in_tdata[55:24];
              acc_r <= '0; mcnt_r <= '0; st_r <= S_MUL; ret_r <= S_BASE;
            end
          end
        end
        S_MUL: begin
          acc_r <= mstep; mplier_r <= mplier_r >> 4; mcand_r <= mcand_r << 4;
          mcnt_r <= mcnt_r + 3'd1;
          if (mcnt_r == 3'd7) st_r <= ret_r;
        end
        S_BASE: begin
          base_r <= acc_r[31:0];
          if (wf_r == mwo_pkg::WF_FSAW) begin
            n_r <= HW'(1); hph_r <= acc_r[31:0]; fsum_r <= '0; st_r <= S_HSIN;
          end else if (wf_r == mwo_pkg::WF_SAW || wf_r == mwo_pkg::WF_NOISE ||
                       wf_r > mwo_pkg::WF_NOISE) begin
            st_r <= S_FIN;
          end else begin
            mcand_r <= 48'(rate_r); mplier_r <= time_r; acc_r <= '0;
            st_r <= S_MUL; ret_r <= S_LPH;
          end
        end
        S_LPH: begin
          hph_r <= acc_r[31:0];
          mcand_r <= 48'(depth_r); mplier_r <= 32'(freq_r); acc_r <= '0;
          st_r <= S_MUL; ret_r <= S_D;
        end
        S_D: begin
          dval_r <= acc_r[47:16];
          sin_r <= tab; st_r <= S_LSIN;
        end
        S_LSIN: begin
          // |s| * d, then 2x and sign
          mcand_r <= 48'(dval_r); mplier_r <= 32'(sin_r < 0 ? -sin_r : sin_r);
          neg_r <= sin_r < 0; acc_r <= '0; st_r <= S_MUL; ret_r <= S_OFF;
        end
        S_OFF: begin
          dval_r <= neg_r ? (32'd0 - {acc_r[30:0], 1'b0}) : {acc_r[30:0], 1'b0};
          mcand_r <= 48'(base_r); mplier_r <= 32'(octv_r); acc_r <= '0;
          st_r <= S_MUL; ret_r <= S_PH;
        end
        S_PH: begin
          hph_r <= acc_r[31:0] + dval_r; st_r <= S_FIN;
        end
        S_HSIN: begin
          // sine of n*base, scaled by 256; start divide by n on the magnitude
          neg_r <= tab < 0;
          dq_r <= 24'({(tab < 0 ? -tab : tab), 8'd0});
          drem_r <= '0; dcnt_r <= '0; st_r <= S_DIV;
        end
        S_DIV: begin
          if (!dtrial[24]) begin
            drem_r <= dtrial[23:0]; dq_r <= {dq_r[22:0], 1'b1};
          end else begin
            drem_r <= {drem_r[22:0], dq_r[23]}; dq_r <= {dq_r[22:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd23) begin
            fsum_r <= fsum_r + (neg_r ? -48'(signed'({1'b0, dq_r[22:0], ~dtrial[24]}))
                                      : 48'({dq_r[22:0], ~dtrial[24]}));
            hph_r <= hph_r + base_r;
            n_r <= n_r + HW'(1);
            if (32'(n_r) + 1 < HARMONICS) st_r <= S_HSIN;
            else st_r <= S_FIN;
          end
        end
        S_FIN: begin
          // wait here while the previous sample still sits in the output register
          if (fin_go) begin
            ovalid_r <= 1'b1; st_r <= S_IDLE;
            if (wf_r == mwo_pkg::WF_NOISE) begin
              lfsr_r <= lfsr_nx;
              odata_r <= (lfsr_nx ^ 16'h8000) & smp;
            end else if (freq_r < minf_r) begin
              odata_r <= '0;
            end else begin
              case (wf_r)
                mwo_pkg::WF_SINE:   odata_r <= tab[15:0] & smp;
                mwo_pkg::WF_SQUARE: odata_r <= (tab > 0 ? 16'h7FFF : 16'h8000) & smp;
                mwo_pkg::WF_TRI:    odata_r <= (hph_r[31] ? 16'(-tri_v) : tri_v[15:0]) & smp;
                mwo_pkg::WF_FSAW:   odata_r <= fs_v[15:0] & smp;
                mwo_pkg::WF_SAW:    odata_r <= (base_r[31:16] ^ 16'h8000) & smp;
                default:            odata_r <= '0;
              endcase
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
